// ===== hdl/erf_pkg.sv =====
// Shared types and constants for the receive address filter.
`default_nettype none
package erf_pkg;

  localparam int MAC_W    = 48;
  localparam int LEN_W    = 14;
  localparam int TL_W     = 16;
  localparam int CNT_W    = 32;
  localparam int IN_W     = 104;
  localparam int OUT_W    = 40;
  localparam int CFG_IDX_W = 2;

  localparam int GROUP_BIT_POS = 40;

  localparam logic [7:0] LLC_PF_BIT = 8'h10;
  localparam logic [7:0] LLC_XID    = 8'hAF;
  localparam logic [7:0] LLC_TEST   = 8'hE3;
  localparam logic [7:0] LLC_NULL_SAP = 8'h00;

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_DEL   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_KEPT     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_MISS     = 3'd3,
    ST_LLC      = 3'd4,
    ST_TBL_OK   = 3'd5,
    ST_TBL_FULL = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC       = 2'd0,
    CFG_PROMISCUOUS   = 2'd1,
    CFG_ALL_MULTICAST = 2'd2,
    CFG_LLC_DROP_EN   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Token passed from cell to cell during a scan.
  typedef struct packed {
    logic valid;
    logic hit;
    logic free;
  } token_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             add;
    logic             del;
    logic             commit;
    logic [MAC_W-1:0] addr;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/erf_cell.sv =====
// One group table entry with its match logic and scan token stage.
`default_nettype none
module erf_cell (
  input  wire                clk,
  input  wire                rst,
  input  erf_pkg::cell_cmd_t cmd,
  input  erf_pkg::token_t    tok_in,
  output erf_pkg::token_t    tok_out
);
  import erf_pkg::*;

  logic             entry_valid;
  logic [MAC_W-1:0] entry;
  logic             claim;
  logic             match;

  assign match = entry_valid && (entry == cmd.addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.hit   <= tok_in.hit | match;
      tok_out.free  <= tok_in.free | ~entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      claim       <= 1'b0;
    end else begin
      if (tok_in.valid) begin
        claim <= cmd.add && !entry_valid && !tok_in.free;
        if (cmd.del && match) begin
          entry_valid <= 1'b0;
        end
      end else if (cmd.commit && claim) begin
        entry_valid <= 1'b1;
        claim       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!tok_in.valid && cmd.commit && claim) begin
      entry <= cmd.addr;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ethernet_receive_address_filter.sv =====
// Top level of the receive address filter: item register, cell chain and decision.
//
// Usage: frame header items enter on the s_ channel, s_tuser carrying the mode
// (check, add group address, delete group address). Each item yields one result
// word on the m_ channel: keep flag, status code and the running LLC drop count.
// The user must write registers through the cfg_ channel only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
// A check, add or delete item walks a token through the chain of
// GROUP_ENTRIES table cells, one cell per cycle, gathering the address hit and
// the first free entry. The result is then decided and, for an add, the claimed
// cell is written. Items are taken only while idle, so the next item is taken
// once the result of the last one has been loaded into the output register.
// A new item is taken while an earlier result still waits in the output
// register; if the receiver stalls, the block holds the finished result of the
// following item until the output register frees.
// Reset empties the group table, clears the LLC drop count and sets the
// registers to their defaults (LLC filter on).
`default_nettype none
module ethernet_receive_address_filter #(
  parameter int GROUP_ENTRIES = 16,
  parameter int MAX_FRAME     = 1514,
  parameter int LLC_MIN_LEN   = 17,
  parameter int LLC_MAX_TYPE  = 1500
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // dest_address, frame_length, type_length, dsap, ssap, llc_control
  input  wire  [erf_pkg::IN_W-1:0]           s_tdata,
  // mode
  input  wire  [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // keep, status, llc_drop_count
  output logic [erf_pkg::OUT_W-1:0]          m_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [erf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [erf_pkg::MAC_W-1:0]          cfg_data
);
  import erf_pkg::*;

  localparam logic [LEN_W-1:0] OVER_LIM = LEN_W'(MAX_FRAME + 4);
  localparam logic [LEN_W-1:0] LLC_LEN  = LEN_W'(LLC_MIN_LEN);
  localparam logic [TL_W-1:0]  LLC_TYPE = TL_W'(LLC_MAX_TYPE);

  logic [MAC_W-1:0] own_mac;
  logic             promiscuous;
  logic             all_multicast;
  logic             llc_drop_enable;

  state_t           state, state_next;
  logic             accept;
  logic             out_free;
  logic             load_out;
  logic             start;

  mode_t            item_mode;
  logic [MAC_W-1:0] item_addr;
  logic [LEN_W-1:0] item_len;
  logic [TL_W-1:0]  item_tl;
  logic [7:0]       item_dsap;
  logic [7:0]       item_ssap;
  logic [7:0]       item_ctrl;

  logic             pend_keep;
  status_t          pend_status;
  logic             pend_commit;
  logic             dec_keep;
  status_t          dec_status;
  logic             dec_commit;
  logic [CNT_W-1:0] llc_drops;
  logic [CNT_W-1:0] count_next;

  cell_cmd_t        cmd;
  token_t           tok [GROUP_ENTRIES+1];
  logic [GROUP_ENTRIES:0] tok_valid;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac         <= '0;
      promiscuous     <= 1'b0;
      all_multicast   <= 1'b0;
      llc_drop_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_MAC:       own_mac         <= cfg_data;
        CFG_PROMISCUOUS:   promiscuous     <= cfg_data[0];
        CFG_ALL_MULTICAST: all_multicast   <= cfg_data[0];
        CFG_LLC_DROP_EN:   llc_drop_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode <= mode_t'(s_tuser);
      item_addr <= s_tdata[47:0];
      item_len  <= s_tdata[61:48];
      item_tl   <= s_tdata[77:62];
      item_dsap <= s_tdata[85:78];
      item_ssap <= s_tdata[93:86];
      item_ctrl <= s_tdata[101:94];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (tok[GROUP_ENTRIES].valid) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE:   s_tready = 1'b1;
      S_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
    end
  end

  assign cmd.addr   = item_addr;
  assign cmd.add    = (item_mode == MODE_ADD);
  assign cmd.del    = (item_mode == MODE_DEL);
  assign cmd.commit = load_out && pend_commit;

  assign tok[0] = '{valid: start, hit: 1'b0, free: 1'b0};

  for (genvar i = 0; i < GROUP_ENTRIES; i++) begin : g_cell
    erf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  for (genvar i = 0; i <= GROUP_ENTRIES; i++) begin : g_tv
    assign tok_valid[i] = tok[i].valid;
  end

  always_comb begin
    logic addr_ok;
    logic llc_hit;
    token_t last;
    last       = tok[GROUP_ENTRIES];
    dec_keep   = 1'b0;
    dec_commit = 1'b0;
    if (promiscuous) begin
      addr_ok = 1'b1;
    end else if (item_addr[GROUP_BIT_POS]) begin
      addr_ok = all_multicast || last.hit;
    end else begin
      addr_ok = (item_addr == own_mac);
    end
    llc_hit = llc_drop_enable && (item_len >= LLC_LEN) && (item_tl <= LLC_TYPE) &&
              (item_dsap == LLC_NULL_SAP) && item_ssap[0] &&
              (((item_ctrl & ~LLC_PF_BIT) == LLC_XID) ||
               ((item_ctrl & ~LLC_PF_BIT) == LLC_TEST));
    case (item_mode)
      MODE_ADD: begin
        if (last.hit) begin
          dec_status = ST_TBL_OK;
        end else if (last.free) begin
          dec_status = ST_TBL_OK;
          dec_commit = 1'b1;
        end else begin
          dec_status = ST_TBL_FULL;
        end
      end
      MODE_DEL: dec_status = ST_TBL_OK;
      default: begin
        if (item_len == '0) begin
          dec_status = ST_EMPTY;
        end else if (item_len > OVER_LIM) begin
          dec_status = ST_OVERSIZE;
        end else if (!addr_ok) begin
          dec_status = ST_MISS;
        end else if (llc_hit) begin
          dec_status = ST_LLC;
        end else begin
          dec_status = ST_KEPT;
          dec_keep   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && tok[GROUP_ENTRIES].valid) begin
      pend_keep   <= dec_keep;
      pend_status <= dec_status;
      pend_commit <= dec_commit;
    end
  end

  assign count_next = (pend_status == ST_LLC) ? llc_drops + 1'b1 : llc_drops;

  always_ff @(posedge clk) begin
    if (rst) begin
      llc_drops <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (load_out) begin
        llc_drops <= count_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'b0, count_next, pend_status, pend_keep};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    tok[GROUP_ENTRIES].valid |-> state == S_SCAN)
    else $error("scan token left the chain outside a scan");

  assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the cell chain");

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (pend_status == ST_TBL_OK && item_mode == MODE_ADD))
    else $error("table write without a successful add");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result word shown without a finished item");

endmodule
`default_nettype wire
